### rtl/cau_pkg.sv
// Shared types, codes and helper functions for the complex arithmetic unit.
// Depends on nothing; complex_arithmetic_unit imports it.
package cau_pkg;

   localparam int DATA_W        = 32;
   localparam int FRAC_BITS_DEF = 16;
   // Quotient bits kept: enough to tell 2^32 and above apart from in-range values.
   localparam int QUO_W         = 33;
   localparam int DIV_STEPS     = QUO_W;

   typedef enum logic [1:0] {
      ACT_ADD = 2'd0,
      ACT_SUB = 2'd1,
      ACT_MUL = 2'd2,
      ACT_DIV = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK  = 2'd0,
      ST_OVF = 2'd1,
      ST_DZ  = 2'd2
   } status_type;

   typedef struct packed {
      logic        ovf;
      logic [31:0] val;
   } sat_type;

   typedef struct packed {
      logic        ovf;
      logic [31:0] re;
      logic [31:0] im;
   } fast_type;

   typedef struct packed {
      logic [1:0]         action;
      logic signed [31:0] ar;
      logic signed [31:0] ai;
      logic signed [31:0] br;
      logic signed [31:0] bi;
   } in_type;

   typedef struct packed {
      logic [1:0]         action;
      fast_type           fast;
      logic signed [63:0] p_rr;
      logic signed [63:0] p_ii;
      logic signed [63:0] p_ri;
      logic signed [63:0] p_ir;
      logic signed [63:0] sq_r;
      logic signed [63:0] sq_i;
   } prod_type;

   typedef struct packed {
      logic               is_div;
      logic               is_mul;
      fast_type           fast;
      logic signed [64:0] mre;
      logic signed [64:0] mim;
      logic signed [64:0] dre;
      logic signed [64:0] dim;
      logic [63:0]        den;
   } sum_type;

   typedef struct packed {
      logic        is_div;
      fast_type    fast;
      logic [63:0] den;
      logic        neg_re;
      logic        neg_im;
      logic [63:0] mag_re;
      logic [63:0] mag_im;
   } mag_type;

   typedef struct packed {
      logic             neg;
      logic             ovfq;
      logic [63:0]      r;
      logic [QUO_W-1:0] dlow;
      logic [QUO_W-1:0] q;
   } part_type;

   typedef struct packed {
      logic        is_div;
      logic        dz;
      fast_type    fast;
      logic [63:0] den;
      part_type    re;
      part_type    im;
   } div_type;

   typedef struct packed {
      logic [31:0] re;
      logic [31:0] im;
      status_type  status;
   } out_type;

   // Saturate a signed 65-bit value to the signed 32-bit range.
   function automatic sat_type sat65(input logic signed [64:0] v);
      sat_type s;
      s.ovf = 1'b0;
      s.val = v[31:0];
      if (v > 65'sd2147483647) begin
         s.ovf = 1'b1;
         s.val = 32'h7FFF_FFFF;
      end else if (v < -65'sd2147483648) begin
         s.ovf = 1'b1;
         s.val = 32'h8000_0000;
      end
      return s;
   endfunction

   // One restoring step: bring in the next dividend bit, subtract if it fits.
   function automatic part_type div_step(input part_type p, input logic [63:0] den);
      part_type   n;
      logic [64:0] t;
      n = p;
      t = {p.r, p.dlow[QUO_W-1]};
      n.dlow = {p.dlow[QUO_W-2:0], 1'b0};
      if (t >= {1'b0, den}) begin
         t = t - {1'b0, den};
         n.q = {p.q[QUO_W-2:0], 1'b1};
      end else begin
         n.q = {p.q[QUO_W-2:0], 1'b0};
      end
      n.r = t[63:0];
      return n;
   endfunction

   // Apply the sign to a finished quotient magnitude and saturate it.
   function automatic sat_type div_clamp(input part_type p);
      sat_type s;
      s.ovf = 1'b0;
      if (p.neg) begin
         if (p.ovfq || p.q > QUO_W'(33'h0_8000_0000)) begin
            s.ovf = 1'b1;
            s.val = 32'h8000_0000;
         end else begin
            s.val = 32'(~p.q + QUO_W'(1));
         end
      end else begin
         if (p.ovfq || p.q > QUO_W'(33'h0_7FFF_FFFF)) begin
            s.ovf = 1'b1;
            s.val = 32'h7FFF_FFFF;
         end else begin
            s.val = p.q[31:0];
         end
      end
      return s;
   endfunction

endpackage

### rtl/cau_req_if.sv
// Request channel of the complex arithmetic unit: valid, ready and operand word.
// Depends on nothing.
interface cau_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         action;
   logic signed [31:0] a_real;
   logic signed [31:0] a_imag;
   logic signed [31:0] b_real;
   logic signed [31:0] b_imag;

   modport source (output valid, action, a_real, a_imag, b_real, b_imag, input ready);
   modport sink   (input valid, action, a_real, a_imag, b_real, b_imag, output ready);
endinterface

### rtl/cau_rsp_if.sv
// Response channel of the complex arithmetic unit: valid, ready and result word.
// Depends on nothing.
interface cau_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] result_real;
   logic signed [31:0] result_imag;
   logic [1:0]         status;

   modport source (output valid, result_real, result_imag, status, input ready);
   modport sink   (input valid, result_real, result_imag, status, output ready);
endinterface

### rtl/complex_arithmetic_unit.sv
// Complex arithmetic unit: a + b, a - b, a * b or a / b on Q16.16 complex words.
// One word is accepted per clock while the pipeline is not stalled, and every word
// passes through the 33-step restoring divider, one quotient bit per stage, on its
// way to the response register. Products are floored,
// quotients truncated toward zero, and out-of-range parts saturate with status 1.
// A zero divisor gives zero parts and status 2. Each stage moves on when the stage
// after it is empty or moving, so bubbles close up and a stalled response holds.
// Depends on cau_pkg, cau_req_if and cau_rsp_if.
module complex_arithmetic_unit #(
   parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   cau_req_if.sink    req_if,
   cau_rsp_if.source  rsp_if
);
   import cau_pkg::*;

   localparam int S_IN   = 0;
   localparam int S_PROD = 1;
   localparam int S_SUM  = 2;
   localparam int S_MAG  = 3;
   localparam int S_DIV0 = 4;
   localparam int S_OUT  = S_DIV0 + DIV_STEPS + 1;
   localparam int NSTG   = S_OUT + 1;
   localparam int DW     = 64 + QUO_W;

   logic [NSTG-1:0] v_ff;
   logic [NSTG-1:0] v_in;
   logic [NSTG-1:0] ld;

   in_type   in_ff,   in_in;
   prod_type prod_ff, prod_in;
   sum_type  sum_ff,  sum_in;
   mag_type  mag_ff,  mag_in;
   div_type  dv_ff [0:DIV_STEPS];
   div_type  dv_in [0:DIV_STEPS];
   out_type  out_ff,  out_in;

   // Stall chain: a stage may load when it is empty or its word moves on.
   assign ld[NSTG-1] = !v_ff[NSTG-1] || rsp_if.ready;
   for (genvar i = 0; i < NSTG - 1; i++) begin : g_ld
      assign ld[i] = !v_ff[i] || ld[i+1];
   end

   assign v_in[0] = ld[0] ? req_if.valid : v_ff[0];
   for (genvar i = 1; i < NSTG; i++) begin : g_vin
      assign v_in[i] = ld[i] ? v_ff[i-1] : v_ff[i];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_if.ready = ld[0];

   // Input register.
   always_comb begin
      in_in.action = req_if.action;
      in_in.ar     = req_if.a_real;
      in_in.ai     = req_if.a_imag;
      in_in.br     = req_if.b_real;
      in_in.bi     = req_if.b_imag;
   end

   // Products, and the add or subtract finished here.
   always_comb begin
      logic signed [32:0] sr;
      logic signed [32:0] si;
      sat_type            tr;
      sat_type            ti;
      if (in_ff.action == ACT_SUB) begin
         sr = 33'(in_ff.ar) - 33'(in_ff.br);
         si = 33'(in_ff.ai) - 33'(in_ff.bi);
      end else begin
         sr = 33'(in_ff.ar) + 33'(in_ff.br);
         si = 33'(in_ff.ai) + 33'(in_ff.bi);
      end
      tr = sat65(65'(sr));
      ti = sat65(65'(si));
      prod_in.action   = in_ff.action;
      prod_in.fast.ovf = tr.ovf || ti.ovf;
      prod_in.fast.re  = tr.val;
      prod_in.fast.im  = ti.val;
      prod_in.p_rr     = in_ff.ar * in_ff.br;
      prod_in.p_ii     = in_ff.ai * in_ff.bi;
      prod_in.p_ri     = in_ff.ar * in_ff.bi;
      prod_in.p_ir     = in_ff.ai * in_ff.br;
      prod_in.sq_r     = in_ff.br * in_ff.br;
      prod_in.sq_i     = in_ff.bi * in_ff.bi;
   end

   // Sums of products, kept exact: numerators at 65 bits, the denominator at 64.
   always_comb begin
      sum_in.is_div = (prod_ff.action == ACT_DIV);
      sum_in.is_mul = (prod_ff.action == ACT_MUL);
      sum_in.fast   = prod_ff.fast;
      sum_in.mre    = 65'(prod_ff.p_rr) - 65'(prod_ff.p_ii);
      sum_in.mim    = 65'(prod_ff.p_ri) + 65'(prod_ff.p_ir);
      sum_in.dre    = 65'(prod_ff.p_rr) + 65'(prod_ff.p_ii);
      sum_in.dim    = 65'(prod_ff.p_ir) - 65'(prod_ff.p_ri);
      sum_in.den    = 64'(prod_ff.sq_r) + 64'(prod_ff.sq_i);
   end

   // Multiply finishes with a floor shift; divide numerators become sign and magnitude.
   always_comb begin
      logic signed [64:0] shr;
      logic signed [64:0] shi;
      sat_type            tr;
      sat_type            ti;
      logic [64:0]        nre;
      logic [64:0]        nim;
      shr = sum_ff.mre >>> FRAC_BITS;
      shi = sum_ff.mim >>> FRAC_BITS;
      tr  = sat65(shr);
      ti  = sat65(shi);
      mag_in.is_div = sum_ff.is_div;
      mag_in.den    = sum_ff.den;
      if (sum_ff.is_mul) begin
         mag_in.fast.ovf = tr.ovf || ti.ovf;
         mag_in.fast.re  = tr.val;
         mag_in.fast.im  = ti.val;
      end else begin
         mag_in.fast = sum_ff.fast;
      end
      nre = sum_ff.dre[64] ? -sum_ff.dre : sum_ff.dre;
      nim = sum_ff.dim[64] ? -sum_ff.dim : sum_ff.dim;
      mag_in.neg_re = sum_ff.dre[64];
      mag_in.neg_im = sum_ff.dim[64];
      mag_in.mag_re = nre[63:0];
      mag_in.mag_im = nim[63:0];
   end

   // Divider entry: split the shifted dividend and test for a quotient of 2^33 or more.
   always_comb begin
      logic [DW-1:0] fre;
      logic [DW-1:0] fim;
      fre = {{QUO_W{1'b0}}, mag_ff.mag_re} << FRAC_BITS;
      fim = {{QUO_W{1'b0}}, mag_ff.mag_im} << FRAC_BITS;
      dv_in[0].is_div  = mag_ff.is_div;
      dv_in[0].dz      = (mag_ff.den == '0);
      dv_in[0].fast    = mag_ff.fast;
      dv_in[0].den     = mag_ff.den;
      dv_in[0].re.neg  = mag_ff.neg_re;
      dv_in[0].re.r    = fre[DW-1:QUO_W];
      dv_in[0].re.ovfq = (fre[DW-1:QUO_W] >= mag_ff.den);
      dv_in[0].re.dlow = fre[QUO_W-1:0];
      dv_in[0].re.q    = '0;
      dv_in[0].im.neg  = mag_ff.neg_im;
      dv_in[0].im.r    = fim[DW-1:QUO_W];
      dv_in[0].im.ovfq = (fim[DW-1:QUO_W] >= mag_ff.den);
      dv_in[0].im.dlow = fim[QUO_W-1:0];
      dv_in[0].im.q    = '0;
   end

   for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
      always_comb begin
         dv_in[k]    = dv_ff[k-1];
         dv_in[k].re = div_step(dv_ff[k-1].re, dv_ff[k-1].den);
         dv_in[k].im = div_step(dv_ff[k-1].im, dv_ff[k-1].den);
      end
   end

   for (genvar k = 0; k <= DIV_STEPS; k++) begin : g_dreg
      always_ff @(posedge clock) begin
         if (ld[S_DIV0+k]) begin
            dv_ff[k] <= dv_in[k];
         end
      end
   end

   // Final selection and status.
   always_comb begin
      sat_type qr;
      sat_type qi;
      logic    ovf;
      qr = div_clamp(dv_ff[DIV_STEPS].re);
      qi = div_clamp(dv_ff[DIV_STEPS].im);
      if (!dv_ff[DIV_STEPS].is_div) begin
         out_in.re = dv_ff[DIV_STEPS].fast.re;
         out_in.im = dv_ff[DIV_STEPS].fast.im;
         ovf       = dv_ff[DIV_STEPS].fast.ovf;
      end else begin
         out_in.re = qr.val;
         out_in.im = qi.val;
         ovf       = qr.ovf || qi.ovf;
      end
      if (dv_ff[DIV_STEPS].is_div && dv_ff[DIV_STEPS].dz) begin
         out_in.re     = '0;
         out_in.im     = '0;
         out_in.status = ST_DZ;
      end else if (ovf) begin
         out_in.status = ST_OVF;
      end else begin
         out_in.status = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (ld[S_IN]) begin
         in_ff <= in_in;
      end
      if (ld[S_PROD]) begin
         prod_ff <= prod_in;
      end
      if (ld[S_SUM]) begin
         sum_ff <= sum_in;
      end
      if (ld[S_MAG]) begin
         mag_ff <= mag_in;
      end
      if (ld[S_OUT]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_if.valid       = v_ff[S_OUT];
   assign rsp_if.result_real = out_ff.re;
   assign rsp_if.result_imag = out_ff.im;
   assign rsp_if.status      = out_ff.status;

`ifndef SYNTH
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> v_ff[S_IN])
      else $error("accepted word did not enter the input stage");

   a_empty_tail_ready: assert property (@(posedge clock) disable iff (reset)
      !v_ff[S_OUT] |-> req_if.ready)
      else $error("request stalled while the response register is empty");

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.status == ST_DZ |->
         rsp_if.result_real == '0 && rsp_if.result_imag == '0)
      else $error("divide-by-zero response carries nonzero parts");

   a_no_code3: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> rsp_if.status == ST_OK || rsp_if.status == ST_OVF ||
         rsp_if.status == ST_DZ)
      else $error("undefined status code on the response");
`endif

endmodule
